[rtl/fcs_pkg.sv]
// fcs_pkg: shared types, codes and the crc byte step for the file checksum engine
// no dependencies; referenced by scoped name from every rtl module
package fcs_pkg;

  localparam logic [1:0] MODE_CRC  = 2'd0;
  localparam logic [1:0] MODE_SYSV = 2'd1;
  localparam logic [1:0] MODE_BSD  = 2'd2;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  localparam int unsigned OUT_BITS = 64;
  localparam int unsigned SUM_BITS = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic byte_en;    // accept one data byte
    logic crc_start;  // end request in crc mode, start feeding the length
    logic feed_en;    // feed one length byte through the crc
    logic crc_done;   // length exhausted, load the crc result
    logic sum_done;   // end request in a sum mode, load the result now
  } fcs_ctrl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_crc;     // mode register selects the crc
    logic len_zero;   // remaining length is zero
  } fcs_stat_t;

  // msb-first crc over one byte, eight shift steps
  function automatic logic [31:0] crc_octet_step(input logic [31:0] crc,
                                                 input logic [7:0]  octet);
    logic [31:0] r;
    r = crc ^ {octet, 24'h0};
    for (int k = 0; k < 8; k++) begin
      r = r[31] ? ({r[30:0], 1'b0} ^ CRC_POLY) : {r[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[rtl/fcs_ctrl.sv]
// fcs_ctrl: request sequencing, length feed state machine and result valid flag
// depends on fcs_pkg
module fcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  fcs_pkg::fcs_stat_t stat,
  output fcs_pkg::fcs_ctrl_t ctrl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_FEED = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_acc;

  // a new request waits during the length feed and while a finished result is still unclaimed
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == fcs_pkg::CMD_DATA) begin
            ctrl.byte_en = 1'b1;
          end else if (stat.is_crc) begin
            ctrl.crc_start = 1'b1;
            state_nxt      = S_FEED;
          end else begin
            ctrl.sum_done = 1'b1;
          end
        end
      end
      S_FEED: begin
        if (stat.len_zero) begin
          ctrl.crc_done = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ctrl.feed_en = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.crc_done || ctrl.sum_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // the result slot is empty for the whole length feed
  a_feed_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FEED) |-> !out_valid_r)
    else $error("result pending during length feed");

  // a new result appears only after a finishing command
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.crc_done || ctrl.sum_done))
    else $error("result raised without a finishing command");

  // the crc finishes only once the length has been fed out
  a_crc_done_len: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.crc_done |-> stat.len_zero && (state_r == S_FEED))
    else $error("crc finished with length remaining");

  // nothing is taken in while the length is being fed
  a_feed_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FEED) |-> !in_tready)
    else $error("request accepted during length feed");

endmodule

[rtl/fcs_dpath.sv]
// fcs_dpath: mode register, running value, byte counter, length shifter, result registers
// depends on fcs_pkg
module fcs_dpath #(
  parameter int unsigned COUNT_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic [7:0]         data_byte,
  input  fcs_pkg::fcs_ctrl_t ctrl,
  output fcs_pkg::fcs_stat_t stat,
  output logic [31:0]        checksum,
  output logic [63:0]        byte_total,
  output logic [63:0]        size_units
);

  logic [1:0]            mode_r;
  logic [31:0]           run_r, run_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] len_r, len_nxt;
  logic [31:0]           chk_r, chk_nxt;
  logic [63:0]           tot_r, tot_nxt;
  logic [63:0]           units_r, units_nxt;

  logic [15:0]           bsd_rot;
  logic [16:0]           fold1;
  logic [16:0]           fold2;
  logic [COUNT_BITS-1:0] blk512;
  logic [COUNT_BITS-1:0] blk1024;

  assign stat.is_crc   = (mode_r == fcs_pkg::MODE_CRC);
  assign stat.len_zero = (len_r == '0);

  // rotate right within 16 bits, taking bit 16 too so a bit left there by a sum stretch still carries down
  assign bsd_rot = run_r[16:1] + {run_r[0], 15'h0};
  assign fold1   = {1'b0, run_r[15:0]} + {1'b0, run_r[31:16]};
  assign fold2   = {1'b0, fold1[15:0]} + {16'h0, fold1[16]};
  assign blk512  = (cnt_r >> 9)  + {{(COUNT_BITS-1){1'b0}}, |cnt_r[8:0]};
  assign blk1024 = (cnt_r >> 10) + {{(COUNT_BITS-1){1'b0}}, |cnt_r[9:0]};

  always_comb begin
    run_nxt   = run_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    chk_nxt   = chk_r;
    tot_nxt   = tot_r;
    units_nxt = units_r;

    if (ctrl.byte_en) begin
      cnt_nxt = cnt_r + {{(COUNT_BITS-1){1'b0}}, 1'b1};
      case (mode_r)
        fcs_pkg::MODE_CRC:  run_nxt = fcs_pkg::crc_octet_step(run_r, data_byte);
        fcs_pkg::MODE_SYSV: run_nxt = run_r + {24'h0, data_byte};
        fcs_pkg::MODE_BSD:  run_nxt = {16'h0, bsd_rot + {8'h0, data_byte}};
        default:            run_nxt = run_r;
      endcase
    end

    if (ctrl.crc_start) begin
      len_nxt = cnt_r;
    end

    // length goes in least significant byte first
    if (ctrl.feed_en) begin
      run_nxt = fcs_pkg::crc_octet_step(run_r, len_r[7:0]);
      len_nxt = len_r >> 8;
    end

    if (ctrl.crc_done) begin
      chk_nxt   = ~run_r;
      tot_nxt   = fcs_pkg::OUT_BITS'(cnt_r);
      units_nxt = fcs_pkg::OUT_BITS'(cnt_r);
      run_nxt   = '0;
      cnt_nxt   = '0;
    end

    if (ctrl.sum_done) begin
      tot_nxt = fcs_pkg::OUT_BITS'(cnt_r);
      case (mode_r)
        fcs_pkg::MODE_SYSV: begin
          chk_nxt   = fcs_pkg::SUM_BITS'(fold2);
          units_nxt = fcs_pkg::OUT_BITS'(blk512);
        end
        fcs_pkg::MODE_BSD: begin
          chk_nxt   = {16'h0, run_r[15:0]};
          units_nxt = fcs_pkg::OUT_BITS'(blk1024);
        end
        default: begin
          // unused mode: no checksum, size in bytes
          chk_nxt   = '0;
          units_nxt = fcs_pkg::OUT_BITS'(cnt_r);
        end
      endcase
      run_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= fcs_pkg::MODE_CRC;
      run_r  <= '0;
      cnt_r  <= '0;
      len_r  <= '0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r   <= chk_nxt;
    tot_r   <= tot_nxt;
    units_r <= units_nxt;
  end

  assign checksum   = chk_r;
  assign byte_total = tot_r;
  assign size_units = units_r;

endmodule

[rtl/file_checksum_engine_unit.sv]
// file_checksum_engine_unit: top level of the whole-file checksum engine
// depends on fcs_pkg, fcs_ctrl and fcs_dpath
//
//  channel  | ports           | payload
//  ---------+-----------------+--------------------------------------------------
//  in_      | tvalid/tready   | tuser: cmd (0 data, 1 end); tdata: data_byte
//  out_     | tvalid/tready   | tdata: checksum, byte_total, size_units
//  cfg_     | we/wdata        | mode (0 crc, 1 sysv sum, 2 bsd sum)
//
// data bytes stream at one per clock while no finished result waits unclaimed
// an end request in a sum mode loads the result straight into the output registers
// an end request in crc mode first feeds the byte count through the crc, low byte
//   first, stopping once the remaining length is zero, and then loads the result
// reset clears mode, running value and byte count; no clearing pass is needed
// the result sits in an output register; only a new request waits while it is unclaimed
module file_checksum_engine_unit #(
  parameter int unsigned COUNT_BITS = 64  // byte counter width, 32 to 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_wdata,     // mode
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,      // [7:0] data_byte
  input  logic         in_tuser,      // [0] cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata      // [31:0] checksum, [95:32] byte_total,
                                      // [159:96] size_units
);

  fcs_pkg::fcs_ctrl_t ctrl;
  fcs_pkg::fcs_stat_t stat;

  logic [31:0] checksum;
  logic [63:0] byte_total;
  logic [63:0] size_units;

  // request sequencing and the result valid flag
  fcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  // running value, byte counter and result registers
  fcs_dpath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .data_byte  (in_tdata),
    .ctrl       (ctrl),
    .stat       (stat),
    .checksum   (checksum),
    .byte_total (byte_total),
    .size_units (size_units)
  );

  assign out_tdata = {size_units, byte_total, checksum};

endmodule

[test/file_checksum_engine_unit_test.sv]
// file_checksum_engine_unit_test: self-checking bench for the whole-file checksum engine
// streams byte and end requests under varied handshake pressure, checks every result
// depends on fcs_pkg and file_checksum_engine_unit
module file_checksum_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // the register allows a fourth mode value that the package does not name
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int unsigned SETTLE_CYCLES = 16;    // covers the longest crc end plus output reg
  localparam int unsigned QUIET_LIMIT   = 4000;  // cycles with no handshake before giving up
  localparam int unsigned RANDOM_ITEMS  = 1050;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned LONG_STREAM   = 512;   // one sysv stream around the 512-byte boundary

  typedef struct packed {
    logic       cmd;
    logic [7:0] octet;
  } file_req_t;

  // laid out as out_tdata: checksum in the low bits, size_units at the top
  typedef struct packed {
    logic [63:0] size_units;
    logic [63:0] byte_total;
    logic [31:0] checksum;
  } cksum_rec_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         cfg_we     = 1'b0;
  logic [1:0]   cfg_wdata  = fcs_pkg::MODE_CRC;
  logic         in_tvalid  = 1'b0;
  logic [7:0]   in_tdata   = 8'h00;   // [7:0] data_byte
  logic         in_tuser   = fcs_pkg::CMD_DATA; // [0] cmd
  logic         out_tready = 1'b0;
  logic         in_tready;
  logic         out_tvalid;
  logic [159:0] out_tdata;            // [31:0] checksum, [95:32] byte_total, [159:96] size_units

  file_checksum_engine_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // requests waiting to be driven, and checksums waiting to come out
  file_req_t  req_q[$];
  cksum_rec_t cksum_expect_q[$];
  file_req_t  held_req;

  // shadow copy of the engine state
  logic [1:0]  mode_shadow  = fcs_pkg::MODE_CRC;
  logic [31:0] acc_shadow   = 32'h0;
  logic [63:0] count_shadow = 64'h0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_cnt        = 0;
  int unsigned req_cnt        = 0;
  int unsigned result_cnt     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned mode_results[4];

  // msb-first crc step over one octet
  function automatic logic [31:0] crc_shift_octet(input logic [31:0] crc,
                                                  input logic [7:0]  octet);
    logic [31:0] r;
    r = crc ^ {octet, 24'h0};
    repeat (8) begin
      if (r[31]) r = {r[30:0], 1'b0} ^ fcs_pkg::CRC_POLY;
      else       r = {r[30:0], 1'b0};
    end
    return r;
  endfunction

  // advance the shadow state by one accepted request; an end request yields a checksum
  task automatic fold_request(input file_req_t req);
    logic [31:0] folded;
    logic [31:0] crc_reg;
    logic [63:0] len;
    cksum_rec_t  rec;
    if (req.cmd == fcs_pkg::CMD_DATA) begin
      count_shadow = count_shadow + 64'd1;
      case (mode_shadow)
        fcs_pkg::MODE_CRC:  acc_shadow = crc_shift_octet(acc_shadow, req.octet);
        fcs_pkg::MODE_SYSV: acc_shadow = acc_shadow + {24'h0, req.octet};
        fcs_pkg::MODE_BSD: begin
          // rotate right within 16 bits; upper bits left by a sysv stretch shift down too
          folded     = (acc_shadow >> 1) + {16'h0, acc_shadow[0], 15'h0};
          acc_shadow = (folded + {24'h0, req.octet}) & 32'h0000_FFFF;
        end
        default: ;  // spare mode only counts
      endcase
    end else begin
      rec.byte_total = count_shadow;
      case (mode_shadow)
        fcs_pkg::MODE_CRC: begin
          // length goes through low byte first, stopping once it runs out
          crc_reg = acc_shadow;
          len     = count_shadow;
          while (len != 64'h0) begin
            crc_reg = crc_shift_octet(crc_reg, len[7:0]);
            len     = len >> 8;
          end
          rec.checksum   = ~crc_reg;
          rec.size_units = count_shadow;
        end
        fcs_pkg::MODE_SYSV: begin
          folded         = {16'h0, acc_shadow[15:0]} + {16'h0, acc_shadow[31:16]};
          rec.checksum   = {16'h0, folded[15:0]} + {16'h0, folded[31:16]};
          rec.size_units = (count_shadow >> 9) + {63'h0, count_shadow[8:0] != 9'h0};
        end
        fcs_pkg::MODE_BSD: begin
          rec.checksum   = acc_shadow & 32'h0000_FFFF;
          rec.size_units = (count_shadow >> 10) + {63'h0, count_shadow[9:0] != 10'h0};
        end
        default: begin
          rec.checksum   = 32'h0;
          rec.size_units = count_shadow;
        end
      endcase
      mode_results[mode_shadow]++;
      cksum_expect_q.push_back(rec);
      acc_shadow   = 32'h0;
      count_shadow = 64'h0;
    end
  endtask

  // driver: holds a request until accepted, otherwise may idle before the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        fold_request(held_req);
        req_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held_req  = req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= held_req.octet;
          in_tuser  <= held_req.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each delivered checksum with the oldest one predicted
  always @(posedge clk) begin
    cksum_rec_t got;
    cksum_rec_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        result_cnt++;
        if (cksum_expect_q.size() == 0) begin
          $error("unexpected result: checksum %h byte_total %0d size_units %0d",
                 got.checksum, got.byte_total, got.size_units);
          err_cnt++;
        end else begin
          want = cksum_expect_q.pop_front();
          if (got.checksum !== want.checksum) begin
            $error("checksum: expected %h, got %h", want.checksum, got.checksum);
            err_cnt++;
          end
          if (got.byte_total !== want.byte_total) begin
            $error("byte_total: expected %0d, got %0d", want.byte_total, got.byte_total);
            err_cnt++;
          end
          if (got.size_units !== want.size_units) begin
            $error("size_units: expected %0d, got %0d", want.size_units, got.size_units);
            err_cnt++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // quiet-cycle counter for the watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[file_checksum_engine_unit] ERROR");
    $finish;
  end

  task automatic push_req(input logic cmd, input logic [7:0] octet);
    file_req_t r;
    r.cmd   = cmd;
    r.octet = octet;
    req_q.push_back(r);
  endtask

  // random bytes, optionally closed by an end request with junk in the data byte
  task automatic queue_stream(input int unsigned len, input bit closed);
    repeat (len) push_req(fcs_pkg::CMD_DATA, 8'($urandom));
    if (closed) push_req(fcs_pkg::CMD_END, 8'($urandom));
  endtask

  // wait until every request is taken and every checksum is back, then let the engine settle
  task automatic drain_block();
    while (req_q.size() != 0 || in_tvalid || cksum_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we      <= 1'b0;
    mode_shadow = m;
  endtask

  initial begin
    int unsigned phase_items;
    int unsigned budget;
    int unsigned len;
    logic [1:0]  phase_mode;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // crc after reset: empty streams back to back, a single byte, two bytes, a short text
    push_req(fcs_pkg::CMD_END, 8'hA5);
    push_req(fcs_pkg::CMD_END, 8'h00);
    push_req(fcs_pkg::CMD_DATA, 8'h00);
    push_req(fcs_pkg::CMD_END, 8'hFF);
    push_req(fcs_pkg::CMD_DATA, 8'hFF);
    push_req(fcs_pkg::CMD_DATA, 8'hFF);
    push_req(fcs_pkg::CMD_END, 8'h5A);
    push_req(fcs_pkg::CMD_DATA, 8'h31);
    push_req(fcs_pkg::CMD_DATA, 8'h32);
    push_req(fcs_pkg::CMD_DATA, 8'h33);
    push_req(fcs_pkg::CMD_END, 8'h00);

    // sysv: one full byte, then an empty stream with zero blocks
    write_mode(fcs_pkg::MODE_SYSV);
    push_req(fcs_pkg::CMD_DATA, 8'hFF);
    push_req(fcs_pkg::CMD_END, 8'h00);
    push_req(fcs_pkg::CMD_END, 8'hFF);

    // switch to bsd with a byte already taken under sysv
    push_req(fcs_pkg::CMD_DATA, 8'h80);
    write_mode(fcs_pkg::MODE_BSD);
    push_req(fcs_pkg::CMD_DATA, 8'h01);
    push_req(fcs_pkg::CMD_END, 8'h00);

    // spare mode value: bytes counted, checksum stays zero
    write_mode(MODE_SPARE);
    push_req(fcs_pkg::CMD_DATA, 8'hFF);
    push_req(fcs_pkg::CMD_END, 8'h00);

    budget = (RANDOM_ITEMS - LONG_STREAM) / NUM_PHASES;
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      phase_mode = 2'(p % 4);
      write_mode(phase_mode);
      case ((p / 2) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      phase_items = 0;
      // around the 512-byte block boundary once, in sysv
      if (p == 1) begin
        len = LONG_STREAM - 1 + $urandom_range(2);
        queue_stream(len, 1'b1);
        phase_items += len + 1;
      end
      while (phase_items < budget) begin
        case ($urandom_range(9))
          0:       len = 0;
          1:       len = $urandom_range(40, 16);
          default: len = $urandom_range(12, 1);
        endcase
        queue_stream(len, 1'b1);
        phase_items += len + 1;
      end
      // sometimes leave a stream open so the next mode picks it up mid-way
      if (p != NUM_PHASES - 1 && $urandom_range(1) == 1) queue_stream($urandom_range(6, 1), 1'b0);
    end

    drain_block();
    $display("covered %0d requests and %0d checksums under four handshake pressures",
             req_cnt, result_cnt);
    $display("checksums per mode: crc %0d, sysv %0d, bsd %0d, spare %0d,",
             mode_results[fcs_pkg::MODE_CRC], mode_results[fcs_pkg::MODE_SYSV],
             mode_results[fcs_pkg::MODE_BSD], mode_results[MODE_SPARE]);
    $display("some modes switched mid-stream");
    if (err_cnt == 0) begin
      $display("[file_checksum_engine_unit] OK");
    end else begin
      $display("[file_checksum_engine_unit] ERROR");
    end
    $finish;
  end

endmodule
